/* sv/cpm_pkg.sv */
// Package for the calendar period matcher: sizes, codes, entry layout and range limits.
package cpm_pkg;

    // Table sizing
    localparam int MAX_RANGES     = 32;
    localparam int MAX_SUBPERIODS = 8;
    localparam int NUM_SCALES     = 9;

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int TAG_W = (MAX_SUBPERIODS > 1) ? $clog2(MAX_SUBPERIODS) : 1;
    localparam int SUB_W = $clog2(MAX_SUBPERIODS + 1);

    // Field widths
    localparam int OP_W    = 3;
    localparam int SCALE_W = 4;
    localparam int VAL_W   = 16;
    localparam int STAT_W  = 2;

    // Range limits per scale
    localparam logic [VAL_W-1:0] YEAR_FLOOR  = 16'd1969;
    localparam logic [VAL_W-1:0] MONTH_END   = 16'd13;
    localparam logic [VAL_W-1:0] WEEK_END    = 16'd7;
    localparam logic [VAL_W-1:0] YDAY_END    = 16'd366;
    localparam logic [VAL_W-1:0] MDAY_END    = 16'd32;
    localparam logic [VAL_W-1:0] WDAY_END    = 16'd8;
    localparam logic [VAL_W-1:0] HOUR_END    = 16'd24;
    localparam logic [VAL_W-1:0] MINSEC_END  = 16'd60;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 3'd0,
        OP_SCALE = 3'd1,
        OP_PUSH  = 3'd2,
        OP_END   = 3'd3,
        OP_QUERY = 3'd4
    } t_opcode;

    typedef enum logic [SCALE_W-1:0] {
        SC_YEAR   = 4'd0,
        SC_MONTH  = 4'd1,
        SC_WEEK   = 4'd2,
        SC_YDAY   = 4'd3,
        SC_MDAY   = 4'd4,
        SC_WDAY   = 4'd5,
        SC_HOUR   = 4'd6,
        SC_MINUTE = 4'd7,
        SC_SECOND = 4'd8
    } t_scale;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_ORDER   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_SCALE = 2'd0,
        PH_LOW   = 2'd1,
        PH_HIGH  = 2'd2,
        PH_NEXT  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_FOLD = 2'd2,
        S_DONE = 2'd3
    } t_state;

    // One stored range
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [SCALE_W-1:0] scale;
        logic [VAL_W-1:0]   low;
        logic [VAL_W-1:0]   high;
    } t_entry;

    // Latched query time
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [2:0]  month_week;
        logic [8:0]  year_day;
        logic [4:0]  month_day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_query;

    // Per-scale bound limits
    function automatic logic value_ok(input logic [SCALE_W-1:0] sc, input logic [VAL_W-1:0] v);
        logic ok;
        case (sc)
            SC_YEAR:   ok = (v > YEAR_FLOOR);
            SC_MONTH:  ok = (v != '0) && (v < MONTH_END);
            SC_WEEK:   ok = (v != '0) && (v < WEEK_END);
            SC_YDAY:   ok = (v != '0) && (v < YDAY_END);
            SC_MDAY:   ok = (v != '0) && (v < MDAY_END);
            SC_WDAY:   ok = (v != '0) && (v < WDAY_END);
            SC_HOUR:   ok = (v < HOUR_END);
            SC_MINUTE: ok = (v < MINSEC_END);
            SC_SECOND: ok = (v < MINSEC_END);
            default:   ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

/* sv/cpm_if.sv */
// Channel interfaces for the calendar period matcher: command words in, result words out.
interface cpm_in_if import cpm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [SCALE_W-1:0] scale;
    logic [VAL_W-1:0]   bound_value;
    logic [15:0]        year;
    logic [3:0]         month;
    logic [2:0]         month_week;
    logic [8:0]         year_day;
    logic [4:0]         month_day;
    logic [2:0]         weekday;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;

    modport source(
        output valid, opcode, scale, bound_value, year, month, month_week,
               year_day, month_day, weekday, hour, minute, second,
        input  ready
    );
    modport sink(
        input  valid, opcode, scale, bound_value, year, month, month_week,
               year_day, month_day, weekday, hour, minute, second,
        output ready
    );
endinterface

interface cpm_out_if import cpm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              matched;
    logic [STAT_W-1:0] status;

    modport source(output valid, matched, status, input ready);
    modport sink(input valid, matched, status, output ready);
endinterface

/* sv/calendar_period_matcher.sv */
// Top level of the calendar period matcher: command decode, range table and query sequencer.
//
// One result word is returned for every command word. Clear, set scale, push bound and
// end sub-period load their result into the output register from the DONE state that
// follows acceptance, once the output register is free. A query walks the stored ranges
// through one registered-read table port and one shared range comparator, one range per
// cycle, then folds the last sub-period in the FOLD state and loads its result from the
// DONE state, as the other commands do.
// Input is taken again in the cycle after the result has moved into the output register,
// which holds it until the sink takes it; a sink that holds off stalls the result and
// then the input. Ranges are kept in load order, so sub-periods are contiguous in the
// table and are scored in a single pass; a closed sub-period that holds no range matches
// every query. The table needs no clearing after reset: only entries below the fill count
// are ever read.
module calendar_period_matcher import cpm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cpm_in_if.sink    i_in,
    cpm_out_if.source o_res
);

    // Control state
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count;
    logic [SUB_W-1:0]     r_sub_idx;
    logic [SCALE_W-1:0]   r_pend_scale;
    logic [VAL_W-1:0]     r_pend_low;
    t_phase               r_phase;

    // Query scan state
    t_query               r_q;
    logic [CNT_W-1:0]     r_rd_idx;
    logic                 r_rv;
    logic                 r_started;
    logic [TAG_W-1:0]     r_cur_tag;
    logic [SUB_W-1:0]     r_groups;
    logic [NUM_SCALES-1:0] r_has;
    logic [NUM_SCALES-1:0] r_hit;
    logic                 r_match;

    // Pending and output result
    logic                 r_res_matched;
    t_status              r_res_status;
    logic                 r_out_valid;
    logic                 r_out_matched;
    t_status              r_out_status;

    // Handshake and decode
    logic                 in_acc;
    logic                 out_free;
    logic                 load_out;
    logic                 issue;
    logic                 ram_re;
    logic                 ram_we;
    logic                 range_ok;
    t_entry               wr_entry;
    t_entry               rd_entry;
    logic [$bits(t_entry)-1:0] rd_bits;
    logic [VAL_W-1:0]     sel_value;
    logic                 cmp_hit;
    logic [NUM_SCALES-1:0] sc_oh;
    logic                 e_closed;
    logic                 new_grp;
    logic                 grp_pass;
    logic                 fold_match;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign issue    = (r_rd_idx < r_count);
    assign range_ok = value_ok(r_pend_scale, r_pend_low)
                      && value_ok(r_pend_scale, i_in.bound_value);

    // Range table
    assign wr_entry.tag   = r_sub_idx[TAG_W-1:0];
    assign wr_entry.scale = r_pend_scale;
    assign wr_entry.low   = r_pend_low;
    assign wr_entry.high  = i_in.bound_value;

    cpm_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_RANGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (rd_bits)
    );

    assign rd_entry = t_entry'(rd_bits);

    // Pick the query field for the entry's scale
    always_comb begin
        case (rd_entry.scale)
            SC_YEAR:   sel_value = r_q.year;
            SC_MONTH:  sel_value = VAL_W'(r_q.month);
            SC_WEEK:   sel_value = VAL_W'(r_q.month_week);
            SC_YDAY:   sel_value = VAL_W'(r_q.year_day);
            SC_MDAY:   sel_value = VAL_W'(r_q.month_day);
            SC_WDAY:   sel_value = VAL_W'(r_q.weekday);
            SC_HOUR:   sel_value = VAL_W'(r_q.hour);
            SC_MINUTE: sel_value = VAL_W'(r_q.minute);
            SC_SECOND: sel_value = VAL_W'(r_q.second);
            default:   sel_value = '0;
        endcase
    end

    cpm_range_cmp u_cmp (
        .i_value (sel_value),
        .i_low   (rd_entry.low),
        .i_high  (rd_entry.high),
        .o_hit   (cmp_hit)
    );

    // Sub-period grouping of the entry under evaluation
    assign sc_oh      = NUM_SCALES'(1) << rd_entry.scale;
    assign e_closed   = (SUB_W'(rd_entry.tag) < r_sub_idx);
    assign new_grp    = !r_started || (rd_entry.tag != r_cur_tag);
    assign grp_pass   = ((r_has & ~r_hit) == '0);
    assign fold_match = r_match || (r_started && grp_pass) || (r_groups != r_sub_idx);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.opcode == OP_QUERY) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (!issue && !r_rv) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_in.ready = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                ram_we     = in_acc && (i_in.opcode == OP_PUSH) && (r_phase == PH_HIGH)
                             && range_ok && (r_count < CNT_W'(MAX_RANGES));
            end
            S_SCAN:  ram_re   = issue;
            S_FOLD:  ram_re   = 1'b0;
            S_DONE:  load_out = out_free;
            default: ram_re   = 1'b0;
        endcase
    end

    // Command execution, query scan and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_sub_idx     <= '0;
            r_pend_scale  <= '0;
            r_pend_low    <= '0;
            r_phase       <= PH_SCALE;
            r_rv          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            // Command decode on acceptance
            if (in_acc) begin
                r_res_matched <= 1'b0;
                r_res_status  <= ST_OK;
                case (i_in.opcode)
                    OP_CLEAR: begin
                        r_count      <= '0;
                        r_sub_idx    <= '0;
                        r_pend_scale <= '0;
                        r_pend_low   <= '0;
                        r_phase      <= PH_SCALE;
                    end
                    OP_SCALE: begin
                        if (i_in.scale >= SCALE_W'(NUM_SCALES)) begin
                            r_res_status <= ST_INVALID;
                        end else if (r_phase != PH_SCALE && r_phase != PH_NEXT) begin
                            r_res_status <= ST_ORDER;
                        end else if (r_sub_idx >= SUB_W'(MAX_SUBPERIODS)) begin
                            r_res_status <= ST_FULL;
                        end else begin
                            r_pend_scale <= i_in.scale;
                            r_phase      <= PH_LOW;
                        end
                    end
                    OP_PUSH: begin
                        if (r_phase == PH_SCALE) begin
                            r_res_status <= ST_ORDER;
                        end else if (r_phase == PH_LOW || r_phase == PH_NEXT) begin
                            r_pend_low <= i_in.bound_value;
                            r_phase    <= PH_HIGH;
                        end else begin
                            if (!range_ok) begin
                                r_res_status <= ST_INVALID;
                            end else if (r_count >= CNT_W'(MAX_RANGES)) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_count <= r_count + 1'b1;
                            end
                            r_phase <= PH_NEXT;
                        end
                    end
                    OP_END: begin
                        if (r_phase != PH_LOW && r_phase != PH_NEXT) begin
                            r_res_status <= ST_ORDER;
                        end else begin
                            r_sub_idx <= r_sub_idx + 1'b1;
                            r_phase   <= PH_SCALE;
                        end
                    end
                    OP_QUERY: begin
                        r_q.year       <= i_in.year;
                        r_q.month      <= i_in.month;
                        r_q.month_week <= i_in.month_week;
                        r_q.year_day   <= i_in.year_day;
                        r_q.month_day  <= i_in.month_day;
                        r_q.weekday    <= i_in.weekday;
                        r_q.hour       <= i_in.hour;
                        r_q.minute     <= i_in.minute;
                        r_q.second     <= i_in.second;
                        r_rd_idx       <= '0;
                        r_rv           <= 1'b0;
                        r_started      <= 1'b0;
                        r_groups       <= '0;
                        r_has          <= '0;
                        r_hit          <= '0;
                        r_match        <= 1'b0;
                    end
                    default: r_res_status <= ST_ORDER;
                endcase
            end

            // Scan: one read issued and one entry scored per cycle
            if (r_state == S_SCAN) begin
                r_rv <= issue;
                if (issue) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                if (r_rv && e_closed) begin
                    if (new_grp) begin
                        if (r_started && grp_pass) begin
                            r_match <= 1'b1;
                        end
                        r_has     <= sc_oh;
                        r_hit     <= cmp_hit ? sc_oh : '0;
                        r_cur_tag <= rd_entry.tag;
                        r_started <= 1'b1;
                        r_groups  <= r_groups + 1'b1;
                    end else begin
                        r_has <= r_has | sc_oh;
                        if (cmp_hit) begin
                            r_hit <= r_hit | sc_oh;
                        end
                    end
                end
            end

            // Close the last sub-period and detect empty ones
            if (r_state == S_FOLD) begin
                r_res_matched <= fold_match;
            end

            // Output register
            if (load_out) begin
                r_out_valid   <= 1'b1;
                r_out_matched <= r_res_matched;
                r_out_status  <= r_res_status;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.matched = r_out_matched;
    assign o_res.status  = r_out_status;

`ifndef NO_ASSERTIONS
    // Fill count stays within the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RANGES))
        else $error("range count beyond table size");

    // Fill count only steps up by one or returns to zero
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> (r_count == $past(r_count) + 1'b1) || (r_count == '0))
        else $error("range count jumped");

    // Closed sub-period count never exceeds its limit
    a_sub_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub_idx <= SUB_W'(MAX_SUBPERIODS))
        else $error("sub-period count beyond limit");

    // An accepted query starts a table scan
    a_query_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.opcode == OP_QUERY)) |=> (r_state == S_SCAN))
        else $error("query did not start a scan");
`endif

endmodule

/* sv/cpm_ram.sv */
// Generic single-port-write, registered-read RAM.
module cpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/cpm_range_cmp.sv */
// Shared range comparator: exact, plain and wrap-around windows.
module cpm_range_cmp import cpm_pkg::*; (
    input  logic [VAL_W-1:0] i_value,
    input  logic [VAL_W-1:0] i_low,
    input  logic [VAL_W-1:0] i_high,
    output logic             o_hit
);

    logic ge_low;
    logic le_high;

    assign ge_low  = (i_value >= i_low);
    assign le_high = (i_value <= i_high);

    // Equal bounds reduce to equality; low above high wraps around
    always_comb begin
        if (i_low == i_high) begin
            o_hit = (i_value == i_low);
        end else if (i_low > i_high) begin
            o_hit = ge_low || le_high;
        end else begin
            o_hit = ge_low && le_high;
        end
    end

endmodule
